// ----- hw/rtl/uart_line_editor_core_macros.svh -----
// Assertion helpers for the line editor core.
`ifndef UART_LINE_EDITOR_CORE_MACROS_SVH
`define UART_LINE_EDITOR_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ULED_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("uled check failed");

// Next-cycle implication, checked out of reset.
`define ULED_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("uled check failed");

`endif

// ----- hw/rtl/uled_pkg.sv -----
package uled_pkg;

    // Field widths
    localparam int CNT_W   = 6;
    localparam int TMO_W   = 16;
    localparam int CODE_W  = 5;

    // Input operations
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_ERROR = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_ECHO    = 3'd0;
    localparam logic [2:0] KIND_CHAR    = 3'd1;
    localparam logic [2:0] KIND_DONE    = 3'd2;
    localparam logic [2:0] KIND_TIMEOUT = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_CHARS = 2'd0;
    localparam logic [1:0] CFG_ECHO      = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT   = 2'd2;

    // Special bytes
    localparam logic [7:0] BYTE_BS    = 8'h08;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_DEL   = 8'h7F;

    // Commands from front to back
    localparam logic [2:0] CMD_STORE   = 3'd0;
    localparam logic [2:0] CMD_ERASE   = 3'd1;
    localparam logic [2:0] CMD_LINE    = 3'd2;
    localparam logic [2:0] CMD_TIMEOUT = 3'd3;
    localparam logic [2:0] CMD_ERROR   = 3'd4;

    // Command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [1:0]        op;
        logic [7:0]        rx_byte;
        logic [CODE_W-1:0] err_code;
    } uled_in_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [7:0]        out_byte;
        logic [CNT_W-1:0]  line_length;
        logic [CODE_W-1:0] error_code_out;
        logic              last;
    } uled_out_t;

    // data: byte to store or error code; count: store index or line length
    typedef struct packed {
        logic [2:0]       cmd;
        logic             echo;
        logic [7:0]       data;
        logic [CNT_W-1:0] count;
    } uled_cmd_t;

endpackage

// ----- hw/rtl/uled_front.sv -----
module uled_front #(
    parameter int LINE_CHARS = 63
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  uled_pkg::uled_in_t  s_data,
    input  logic                q_full,
    output logic                q_push,
    output uled_pkg::uled_cmd_t q_cmd
);
    import uled_pkg::*;

    localparam logic [CNT_W-1:0] LINE_LIM = CNT_W'(LINE_CHARS);

    logic [CNT_W-1:0] max_chars_reg, max_chars_next;
    logic             echo_reg, echo_next;
    logic [TMO_W-1:0] timeout_reg, timeout_next;
    logic [TMO_W-1:0] wait_reg, wait_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] limit;
    logic             accept;
    logic             printable;

    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign limit     = (max_chars_reg < LINE_LIM) ? max_chars_reg : LINE_LIM;
    assign printable = (s_data.rx_byte >= BYTE_SPACE) && (s_data.rx_byte <= BYTE_DEL);

    // Classify the request, update line state, queue the work
    always_comb begin
        max_chars_next = max_chars_reg;
        echo_next      = echo_reg;
        timeout_next   = timeout_reg;
        wait_next      = wait_reg;
        count_next     = count_reg;
        q_push         = 1'b0;
        q_cmd          = '0;
        q_cmd.echo     = echo_reg;

        if (accept) begin
            case (s_data.op)
                OP_BYTE: begin
                    if (s_data.rx_byte == BYTE_LF || s_data.rx_byte == BYTE_CR) begin
                        q_push      = 1'b1;
                        q_cmd.cmd   = CMD_LINE;
                        q_cmd.count = count_reg;
                        count_next  = '0;
                        wait_next   = timeout_reg;
                    end else if (s_data.rx_byte == BYTE_BS) begin
                        if (count_reg != '0) begin
                            count_next = count_reg - 1'b1;
                            q_push     = echo_reg;
                            q_cmd.cmd  = CMD_ERASE;
                        end
                    end else if (printable && count_reg < limit) begin
                        q_push      = 1'b1;
                        q_cmd.cmd   = CMD_STORE;
                        q_cmd.data  = s_data.rx_byte;
                        q_cmd.count = count_reg;
                        count_next  = count_reg + 1'b1;
                    end
                end
                OP_TICK: begin
                    if (wait_reg != '0) begin
                        wait_next = wait_reg - 1'b1;
                        if (wait_reg == TMO_W'(1)) begin
                            q_push     = 1'b1;
                            q_cmd.cmd  = CMD_TIMEOUT;
                            count_next = '0;
                            wait_next  = timeout_reg;
                        end
                    end
                end
                OP_ERROR: begin
                    if (s_data.err_code != '0) begin
                        q_push     = 1'b1;
                        q_cmd.cmd  = CMD_ERROR;
                        q_cmd.data = 8'(s_data.err_code);
                        count_next = '0;
                        wait_next  = timeout_reg;
                    end
                end
                default: begin
                end
            endcase
        end

        // The user must write registers only while idle; the block itself does not enforce it.
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MAX_CHARS: max_chars_next = cfg_wr_data[CNT_W-1:0];
                CFG_ECHO:      echo_next      = cfg_wr_data[0];
                CFG_TIMEOUT: begin
                    timeout_next = cfg_wr_data;
                    wait_next    = cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_chars_reg <= 6'd63;
            echo_reg      <= 1'b0;
            timeout_reg   <= '0;
            wait_reg      <= '0;
            count_reg     <= '0;
        end else begin
            max_chars_reg <= max_chars_next;
            echo_reg      <= echo_next;
            timeout_reg   <= timeout_next;
            wait_reg      <= wait_next;
            count_reg     <= count_next;
        end
    end

endmodule

// ----- hw/rtl/uled_queue.sv -----
module uled_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  uled_pkg::uled_cmd_t push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                avail,
    output uled_pkg::uled_cmd_t head_cmd
);
    import uled_pkg::*;

    uled_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    fill_reg, fill_next;

    assign full     = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign avail    = (fill_reg != '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hw/rtl/uled_back.sv -----
`include "uart_line_editor_core_macros.svh"

module uled_back #(
    parameter int LINE_CHARS = 63
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_avail,
    input  uled_pkg::uled_cmd_t q_cmd,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output uled_pkg::uled_out_t m_data
);
    import uled_pkg::*;

    localparam int IDX_W = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_CHR  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [7:0]       line_mem [LINE_CHARS];
    logic [7:0]       rd_data_reg;
    logic             mem_we;

    logic [1:0]       state_reg, state_next;
    uled_cmd_t        cmd_reg, cmd_next;
    logic [1:0]       step_reg, step_next;
    logic [CNT_W-1:0] walk_reg, walk_next;
    logic             m_valid_reg, m_valid_next;
    uled_out_t        m_res_reg;
    uled_out_t        res_next;
    logic             res_load;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_res_reg;

    // Command sequencer
    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        step_next  = step_reg;
        walk_next  = walk_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        res_load   = 1'b0;
        res_next   = '0;

        case (state_reg)
            ST_IDLE: begin
                if (q_avail) begin
                    q_pop     = 1'b1;
                    cmd_next  = q_cmd;
                    step_next = '0;
                    walk_next = '0;
                    case (q_cmd.cmd)
                        CMD_STORE: begin
                            mem_we = 1'b1;
                            if (q_cmd.echo) begin
                                state_next = ST_OUT;
                            end
                        end
                        CMD_LINE: begin
                            state_next = (q_cmd.count == '0) ? ST_OUT : ST_RD;
                        end
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_RD: begin
                // store read is registered: the byte is fetched here for ST_CHR
                state_next = ST_CHR;
            end
            ST_CHR: begin
                if (out_free) begin
                    res_load          = 1'b1;
                    res_next.kind     = KIND_CHAR;
                    res_next.out_byte = rd_data_reg;
                    walk_next         = walk_reg + 1'b1;
                    state_next = (walk_next == cmd_reg.count) ? ST_OUT : ST_RD;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    res_load      = 1'b1;
                    res_next.last = 1'b1;
                    state_next    = ST_IDLE;
                    case (cmd_reg.cmd)
                        CMD_STORE: begin
                            res_next.kind     = KIND_ECHO;
                            res_next.out_byte = cmd_reg.data;
                        end
                        CMD_ERASE: begin
                            // BS, space, BS
                            res_next.kind     = KIND_ECHO;
                            res_next.out_byte = (step_reg == 2'd1) ? BYTE_SPACE : BYTE_BS;
                            res_next.last     = (step_reg == 2'd2);
                            step_next         = step_reg + 1'b1;
                            if (step_reg != 2'd2) begin
                                state_next = ST_OUT;
                            end
                        end
                        CMD_LINE: begin
                            res_next.kind        = KIND_DONE;
                            res_next.line_length = cmd_reg.count;
                        end
                        CMD_TIMEOUT: begin
                            res_next.kind = KIND_TIMEOUT;
                        end
                        CMD_ERROR: begin
                            res_next.kind           = KIND_ERROR;
                            res_next.error_code_out = cmd_reg.data[CODE_W-1:0];
                        end
                        default: begin
                            res_load = 1'b0;
                        end
                    endcase
                end
            end
            default: state_next = ST_IDLE;
        endcase

        m_valid_next = res_load || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            walk_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            walk_reg    <= walk_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        if (res_load) begin
            m_res_reg <= res_next;
        end
    end

    // Line store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[q_cmd.count[IDX_W-1:0]] <= q_cmd.data;
        end
        rd_data_reg <= line_mem[walk_reg[IDX_W-1:0]];
    end

    // Walk never passes the line length
    `ULED_ASSERT_IMP(a_walk_in_line, aclk, aresetn, (state_reg == ST_RD || state_reg == ST_CHR), (walk_reg < cmd_reg.count))
    // A line character is never the final result of a request
    `ULED_ASSERT_IMP(a_char_not_last, aclk, aresetn, (m_valid_reg && m_res_reg.kind == KIND_CHAR), (!m_res_reg.last))
    // Once the completion result is loaded the sequencer is free again
    `ULED_ASSERT_NEXT(a_done_frees, aclk, aresetn, (res_load && res_next.kind == KIND_DONE), (state_reg == ST_IDLE))

endmodule

// ----- hw/rtl/uart_line_editor_core.sv -----
// Channel   Ports                         Moves
// input     s_valid s_ready s_data        one received event (byte, tick, error)
// result    m_valid m_ready m_data        one echo, line character or line status
// config    cfg_wr_en cfg_index cfg_wr_data  register write, no wait
//
// The front takes one request per cycle while the 4-entry command queue has room.
// Results leave one per cycle at most; a finished line walks the store through
// ST_RD and ST_CHR for each character (registered store read).
// Reset is synchronous on aresetn low; the line store is not cleared.
// A stalled m_ready holds the result register; the front keeps taking requests
// until the queue fills.
module uart_line_editor_core #(
    parameter int LINE_CHARS = 63
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  uled_pkg::uled_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output uled_pkg::uled_out_t m_data
);
    import uled_pkg::*;

    logic      q_full;
    logic      q_push;
    logic      q_pop;
    logic      q_avail;
    uled_cmd_t push_cmd;
    uled_cmd_t head_cmd;

    uled_front #(
        .LINE_CHARS (LINE_CHARS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    uled_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .avail    (q_avail),
        .head_cmd (head_cmd)
    );

    uled_back #(
        .LINE_CHARS (LINE_CHARS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_avail (q_avail),
        .q_cmd   (head_cmd),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- tb/sv/tb_uart_line_editor_core.sv -----
`timescale 1ns / 100ps

module tb_uart_line_editor_core;
    import uled_pkg::*;

    localparam int LINE_CHARS    = 63;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // leave room for a full line walk and for queued requests
    localparam int SETTLE_CYCLES = 600;
    localparam int STALL_LIMIT   = 4000;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 50;
    localparam int PRESSURE_PHASE = 4;

    // per-phase register settings and idling
    localparam logic [15:0] PH_MAX [PHASES] =
        '{16'd63, 16'd63, 16'd0, 16'hFFC8, 16'd63, 16'd1, 16'd40, 16'd63};
    localparam logic [15:0] PH_ECHO [PHASES] =
        '{16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'd1, 16'd0};
    localparam logic [15:0] PH_TMO [PHASES] =
        '{16'd0, 16'd0, 16'd5, 16'd20, 16'd65535, 16'd1, 16'd40, 16'd12};
    localparam int PH_SEND_IDLE [PHASES] = '{0, 87, 0, 24, 0, 87, 0, 24};
    localparam int PH_RECV_STALL [PHASES] = '{0, 0, 87, 24, 0, 0, 87, 24};

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_index   = '0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    uled_in_t    s_data      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    uled_out_t   m_data;

    uart_line_editor_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always #4 aclk = ~aclk;

    // line editor state as seen by the predictor
    logic [7:0]  line_buf [LINE_CHARS];
    logic [5:0]  char_cnt    = '0;
    logic [15:0] ticks_left  = '0;
    logic [5:0]  max_chars_q = 6'd63;
    logic        echo_on     = 1'b0;
    logic [15:0] timeout_q   = '0;

    uled_out_t editor_out_q [$];
    uled_in_t  rx_event_q [$];

    int   n_pushed       = 0;
    int   n_accepted     = 0;
    int   fail_count     = 0;
    int   quiet_cycles   = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic s_took         = 1'b0;

    function automatic void add_result(logic [2:0] kind, logic [7:0] b, logic [5:0] len,
                                       logic [4:0] code);
        uled_out_t r;
        r.kind           = kind;
        r.out_byte       = b;
        r.line_length    = len;
        r.error_code_out = code;
        r.last           = 1'b0;
        editor_out_q.push_back(r);
    endfunction

    function automatic void restart_line();
        char_cnt   = '0;
        ticks_left = timeout_q;
    endfunction

    // one received event -> echoes, line characters or line status
    function automatic void line_edit(uled_in_t ev);
        int        n_before;
        int        i;
        uled_out_t tail;
        n_before = editor_out_q.size();
        case (ev.op)
            OP_BYTE: begin
                if (ev.rx_byte == BYTE_LF || ev.rx_byte == BYTE_CR) begin
                    for (i = 0; i < int'(char_cnt); i++)
                        add_result(KIND_CHAR, line_buf[i], '0, '0);
                    add_result(KIND_DONE, '0, char_cnt, '0);
                    restart_line();
                end else if (ev.rx_byte == BYTE_BS) begin
                    if (char_cnt != 0) begin
                        char_cnt = char_cnt - 6'd1;
                        if (echo_on) begin
                            add_result(KIND_ECHO, BYTE_BS, '0, '0);
                            add_result(KIND_ECHO, BYTE_SPACE, '0, '0);
                            add_result(KIND_ECHO, BYTE_BS, '0, '0);
                        end
                    end
                end else if (ev.rx_byte >= BYTE_SPACE && ev.rx_byte <= BYTE_DEL &&
                             char_cnt < max_chars_q) begin
                    line_buf[char_cnt] = ev.rx_byte;
                    char_cnt = char_cnt + 6'd1;
                    if (echo_on)
                        add_result(KIND_ECHO, ev.rx_byte, '0, '0);
                end
            end
            OP_TICK: begin
                // zero budget means the timeout is off
                if (ticks_left != 0) begin
                    ticks_left = ticks_left - 16'd1;
                    if (ticks_left == 0) begin
                        add_result(KIND_TIMEOUT, '0, '0, '0);
                        restart_line();
                    end
                end
            end
            OP_ERROR: begin
                if (ev.err_code != 0) begin
                    add_result(KIND_ERROR, '0, '0, ev.err_code);
                    restart_line();
                end
            end
            default: ;
        endcase
        if (editor_out_q.size() > n_before) begin
            tail = editor_out_q.pop_back();
            tail.last = 1'b1;
            editor_out_q.push_back(tail);
        end
    endfunction

    function automatic void push_event(logic [1:0] op, logic [7:0] b, logic [4:0] code);
        uled_in_t ev;
        ev.op       = op;
        ev.rx_byte  = b;
        ev.err_code = code;
        rx_event_q.push_back(ev);
        n_pushed++;
    endfunction

    // random line: printable text with erases, ticks and some noise, then most often an ending
    function automatic int queue_random_line();
        int         n_chars;
        int         counted;
        int         pick;
        int         i;
        int         k;
        logic [7:0] junk;
        logic [4:0] code;
        counted = 0;
        if ($urandom_range(11) == 0)
            n_chars = $urandom_range(70, 40);
        else
            n_chars = $urandom_range(8);
        for (i = 0; i < n_chars; i++) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                push_event(OP_BYTE, BYTE_BS, 5'($urandom));
                counted++;
            end else if (pick < 16) begin
                push_event(OP_TICK, 8'($urandom), 5'($urandom));
                counted++;
            end else if (pick < 20) begin
                // ignored requests: control bytes, high bytes, error zero, unused op
                case ($urandom_range(3))
                    0: begin
                        junk = 8'($urandom_range(31));
                        if (junk == BYTE_BS || junk == BYTE_LF || junk == BYTE_CR)
                            junk = 8'h1B;
                        push_event(OP_BYTE, junk, 5'($urandom));
                    end
                    1: push_event(OP_BYTE, 8'($urandom_range(255, 128)), 5'($urandom));
                    2: push_event(OP_ERROR, 8'($urandom), 5'd0);
                    default: push_event(OP_UNUSED, 8'($urandom), 5'($urandom));
                endcase
            end else begin
                push_event(OP_BYTE, 8'($urandom_range(127, 32)), 5'($urandom));
                counted++;
            end
        end
        pick = $urandom_range(99);
        if (pick < 70) begin
            push_event(OP_BYTE, ($urandom_range(1) != 0) ? BYTE_CR : BYTE_LF, 5'($urandom));
            counted++;
        end else if (pick < 82) begin
            case ($urandom_range(2))
                0: code = 5'd2;
                1: code = 5'($urandom_range(31, 16));
                default: code = 5'($urandom_range(31, 1));
            endcase
            push_event(OP_ERROR, 8'($urandom), code);
            counted++;
        end else if (pick < 92) begin
            for (k = $urandom_range(1, 25); k > 0; k--) begin
                push_event(OP_TICK, 8'($urandom), 5'($urandom));
                counted++;
            end
        end
        return counted;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        case (idx)
            CFG_MAX_CHARS: max_chars_q = val[5:0];
            CFG_ECHO:      echo_on = val[0];
            CFG_TIMEOUT: begin
                timeout_q  = val;
                ticks_left = val;
            end
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain_results();
        while (n_accepted != n_pushed || editor_out_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic wait_idle();
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (rx_event_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_data  <= rx_event_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result backpressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // predict on accepted requests, check accepted results
    always @(posedge aclk) begin : result_check
        uled_out_t want;
        s_took = aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_took) begin
                line_edit(s_data);
                n_accepted++;
            end
            if (m_valid && m_ready) begin
                if (editor_out_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected: kind %0d byte %02h len %0d code %0d last %0b",
                                 m_data.kind, m_data.out_byte, m_data.line_length,
                                 m_data.error_code_out, m_data.last);
                end else begin
                    want = editor_out_q.pop_front();
                    if (m_data.kind !== want.kind || m_data.out_byte !== want.out_byte ||
                        m_data.line_length !== want.line_length ||
                        m_data.error_code_out !== want.error_code_out ||
                        m_data.last !== want.last) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("mismatch exp: kind %0d byte %02h len %0d code %0d last %0b",
                                     want.kind, want.out_byte, want.line_length,
                                     want.error_code_out, want.last);
                            $display("         got: kind %0d byte %02h len %0d code %0d last %0b",
                                     m_data.kind, m_data.out_byte, m_data.line_length,
                                     m_data.error_code_out, m_data.last);
                        end
                    end
                end
            end
            quiet_cycles = (s_took || (m_valid && m_ready)) ? 0 : quiet_cycles + 1;
        end
    end

    // watchdog on handshake activity
    always @(negedge aclk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int ph;
        int counted;
        bit paused;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // short line limit with echo: edges of printable range, full line, erase, ends
        write_reg(CFG_MAX_CHARS, 16'd3);
        write_reg(CFG_ECHO, 16'd1);
        write_reg(CFG_TIMEOUT, 16'd0);
        push_event(OP_BYTE, BYTE_SPACE, 5'd31);
        push_event(OP_BYTE, BYTE_DEL, 5'd0);
        push_event(OP_BYTE, 8'h41, 5'd21);
        push_event(OP_BYTE, 8'h42, 5'd10);      // line full
        push_event(OP_BYTE, 8'h1F, 5'd0);       // control byte
        push_event(OP_BYTE, 8'hFF, 5'd31);      // high byte
        push_event(OP_BYTE, BYTE_BS, 5'd0);
        push_event(OP_BYTE, BYTE_CR, 5'd0);
        push_event(OP_BYTE, BYTE_BS, 5'd0);     // erase on empty line
        push_event(OP_BYTE, BYTE_LF, 5'd0);     // empty line
        push_event(OP_TICK, 8'hFF, 5'd31);      // timeout off
        push_event(OP_ERROR, 8'hFF, 5'd0);      // no error
        push_event(OP_UNUSED, 8'hFF, 5'd31);
        push_event(OP_BYTE, 8'h78, 5'd0);
        push_event(OP_ERROR, 8'h00, 5'd31);     // abandons the line
        push_event(OP_ERROR, 8'h00, 5'd2);
        push_event(OP_BYTE, BYTE_CR, 5'd0);
        wait_idle();

        // total tick budget across the line
        write_reg(CFG_ECHO, 16'd0);
        write_reg(CFG_MAX_CHARS, 16'd63);
        write_reg(CFG_TIMEOUT, 16'd3);
        push_event(OP_TICK, 8'h00, 5'd0);
        push_event(OP_BYTE, 8'h61, 5'd0);
        push_event(OP_TICK, 8'h00, 5'd0);
        push_event(OP_TICK, 8'h00, 5'd0);
        push_event(OP_BYTE, BYTE_CR, 5'd0);
        wait_idle();

        // limit lowered under the kept count
        push_event(OP_BYTE, 8'h68, 5'd0);
        push_event(OP_BYTE, 8'h65, 5'd0);
        push_event(OP_BYTE, 8'h6C, 5'd0);
        wait_idle();
        write_reg(CFG_MAX_CHARS, 16'd2);
        push_event(OP_BYTE, 8'h78, 5'd0);
        push_event(OP_BYTE, BYTE_CR, 5'd0);

        // random lines under several settings
        for (ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            write_reg(CFG_MAX_CHARS, PH_MAX[ph]);
            write_reg(CFG_ECHO, PH_ECHO[ph]);
            write_reg(CFG_TIMEOUT, PH_TMO[ph]);
            send_idle_pct  = PH_SEND_IDLE[ph];
            recv_stall_pct = PH_RECV_STALL[ph];
            counted = 0;
            paused  = 1'b0;
            while (counted < PHASE_ITEMS) begin
                // sender holds until every pending result is out
                if (ph == PRESSURE_PHASE && !paused && counted >= PHASE_ITEMS / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
                counted += queue_random_line();
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
